// ===== sv/tvmp_pkg.sv =====
`timescale 1ns / 1ps

package tvmp_pkg;

  localparam logic [31:0] MaxBufferBytes = 32'd65535;
  localparam logic [7:0]  ContBit        = 8'h80;
  localparam logic [7:0]  PayloadMask    = 8'h7f;
  localparam logic [3:0]  SizeWordBytes  = 4'd4;
  localparam logic [2:0]  VarintMaxBytes = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SIZE  = 3'd1,
    PH_VER   = 3'd2,
    PH_RLEN  = 3'd3,
    PH_TYPE  = 3'd4,
    PH_NLEN  = 3'd5,
    PH_NAME  = 3'd6,
    PH_VALUE = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_SIZE_WORD = 3'd0,
    ROLE_VERSION   = 3'd1,
    ROLE_REC_LEN   = 3'd2,
    ROLE_TYPE      = 3'd3,
    ROLE_NAME_LEN  = 3'd4,
    ROLE_NAME      = 3'd5,
    ROLE_VALUE     = 3'd6,
    ROLE_IGNORED   = 3'd7
  } role_t;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_DONE_OK   = 3'd1,
    ST_SHORT_BUF = 3'd2,
    ST_SIZE_BIG  = 3'd3,
    ST_BAD_VER   = 3'd4,
    ST_REC_OVR   = 3'd5,
    ST_NAME_OVR  = 3'd6,
    ST_VARINT    = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_req;
    logic [15:0] buffer_size;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    role_t       role;
    logic [15:0] record_index;
    logic [31:0] record_type;
    logic [31:0] varint_value;
    logic        varint_done;
    status_t     status;
    logic        last;
  } out_item_t;

  function automatic role_t phase_role(input phase_t ph);
    role_t r;
    r = ROLE_IGNORED;
    unique case (ph)
      PH_SIZE:  r = ROLE_SIZE_WORD;
      PH_VER:   r = ROLE_VERSION;
      PH_RLEN:  r = ROLE_REC_LEN;
      PH_TYPE:  r = ROLE_TYPE;
      PH_NLEN:  r = ROLE_NAME_LEN;
      PH_NAME:  r = ROLE_NAME;
      PH_VALUE: r = ROLE_VALUE;
      default:  r = ROLE_IGNORED;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] varint_shift(input logic [2:0] cnt);
    logic [4:0] s;
    s = 5'd0;
    case (cnt)
      3'd0:    s = 5'd0;
      3'd1:    s = 5'd7;
      3'd2:    s = 5'd14;
      3'd3:    s = 5'd21;
      3'd4:    s = 5'd28;
      3'd5:    s = 5'd0;
      3'd6:    s = 5'd7;
      default: s = 5'd14;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/tvmp_in_reg.sv =====
`timescale 1ns / 1ps

module tvmp_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tvmp_pkg::in_item_t in_item,
  output logic               held_valid,
  output tvmp_pkg::in_item_t held_item,
  input  logic               held_take
);
  import tvmp_pkg::*;

  assign in_ready = !held_valid || held_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== sv/tvmp_core.sv =====
`timescale 1ns / 1ps

module tvmp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  tvmp_pkg::in_item_t  item,
  input  logic [7:0]          max_version,
  output tvmp_pkg::out_item_t result
);
  import tvmp_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] varint_acc, varint_acc_next;
  logic [2:0]  varint_count, varint_count_next;
  logic [31:0] record_left, record_left_next;
  logic [31:0] name_left, name_left_next;
  logic [3:0]  header_count, header_count_next;
  logic [31:0] current_type, current_type_next;
  logic [15:0] record_counter, record_counter_next;
  logic [31:0] size_word, size_word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bytes_remaining <= '0;
      varint_acc     <= '0;
      varint_count   <= '0;
      record_left    <= '0;
      name_left      <= '0;
      header_count   <= '0;
      current_type   <= '0;
      record_counter <= '0;
      size_word      <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      bytes_remaining <= bytes_remaining_next;
      varint_acc     <= varint_acc_next;
      varint_count   <= varint_count_next;
      record_left    <= record_left_next;
      name_left      <= name_left_next;
      header_count   <= header_count_next;
      current_type   <= current_type_next;
      record_counter <= record_counter_next;
      size_word      <= size_word_next;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [31:0] v;
    b = item.data_byte;
    v = '0;
    phase_next           = phase;
    bytes_remaining_next = bytes_remaining;
    varint_acc_next      = varint_acc;
    varint_count_next    = varint_count;
    record_left_next     = record_left;
    name_left_next       = name_left;
    header_count_next    = header_count;
    current_type_next    = current_type;
    record_counter_next  = record_counter;
    size_word_next       = size_word;
    result.byte_out      = b;
    result.role          = ROLE_IGNORED;
    result.varint_value  = '0;
    result.varint_done   = 1'b0;
    result.status        = ST_BUSY;
    result.last          = 1'b0;

    if (item.start_req) begin
      bytes_remaining_next = ({16'd0, item.buffer_size} > MaxBufferBytes) ?
                             MaxBufferBytes[15:0] : item.buffer_size;
      varint_acc_next     = '0;
      varint_count_next   = '0;
      record_left_next    = '0;
      name_left_next      = '0;
      header_count_next   = '0;
      current_type_next   = '0;
      record_counter_next = '0;
      size_word_next      = '0;
      phase_next          = PH_SIZE;
      if (bytes_remaining_next < {12'd0, SizeWordBytes}) begin
        result.role   = ROLE_SIZE_WORD;
        result.status = ST_SHORT_BUF;
        result.last   = 1'b1;
        phase_next    = PH_IDLE;
      end
    end
    result.record_index = record_counter_next;

    if (phase_next != PH_IDLE) begin
      result.role = phase_role(phase_next);
      bytes_remaining_next = bytes_remaining_next - 16'd1;
      unique case (phase_next)
        PH_SIZE: begin
          size_word_next = size_word_next |
                           ({24'd0, b} << {header_count_next[1:0], 3'b000});
          header_count_next = header_count_next + 4'd1;
          if (header_count_next >= SizeWordBytes) begin
            if ({1'b0, size_word_next} >
                ({17'd0, bytes_remaining_next} + 33'd4)) begin
              result.status = ST_SIZE_BIG;
            end else begin
              phase_next        = PH_VER;
              varint_acc_next   = '0;
              varint_count_next = '0;
            end
          end
        end
        PH_NAME: begin
          name_left_next = name_left_next - 32'd1;
          if (name_left_next == '0) begin
            if (record_left_next != '0) begin
              phase_next = PH_VALUE;
            end else begin
              record_counter_next = record_counter_next + 16'd1;
              phase_next          = PH_RLEN;
              varint_acc_next     = '0;
              varint_count_next   = '0;
            end
          end
        end
        PH_VALUE: begin
          record_left_next = record_left_next - 32'd1;
          if (record_left_next == '0) begin
            record_counter_next = record_counter_next + 16'd1;
            phase_next          = PH_RLEN;
            varint_acc_next     = '0;
            varint_count_next   = '0;
          end
        end
        default: begin
          if (phase_next == PH_TYPE || phase_next == PH_NLEN) begin
            header_count_next = header_count_next + 4'd1;
          end
          varint_acc_next = varint_acc_next |
                            ({24'd0, b & PayloadMask} << varint_shift(varint_count_next));
          if ((b & ContBit) != 8'd0) begin
            varint_count_next = varint_count_next + 3'd1;
            if (varint_count_next >= VarintMaxBytes) begin
              result.status = ST_VARINT;
            end
          end else begin
            v = varint_acc_next;
            result.varint_done  = 1'b1;
            result.varint_value = v;
            varint_acc_next     = '0;
            varint_count_next   = '0;
            if (phase_next == PH_VER) begin
              if (v > {24'd0, max_version}) begin
                result.status = ST_BAD_VER;
              end else begin
                phase_next = PH_RLEN;
              end
            end else if (phase_next == PH_RLEN) begin
              if (v > {16'd0, bytes_remaining_next}) begin
                result.status = ST_REC_OVR;
              end else begin
                record_left_next  = v;
                header_count_next = '0;
                phase_next        = PH_TYPE;
              end
            end else if (phase_next == PH_TYPE) begin
              current_type_next = v;
              phase_next        = PH_NLEN;
            end else begin
              if (v > {16'd0, bytes_remaining_next} ||
                  ({1'b0, v} + {29'd0, header_count_next}) > {1'b0, record_left_next}) begin
                result.status = ST_NAME_OVR;
              end else begin
                record_left_next = record_left_next - {28'd0, header_count_next} - v;
                name_left_next   = v;
                if (v != '0) begin
                  phase_next = PH_NAME;
                end else if (record_left_next != '0) begin
                  phase_next = PH_VALUE;
                end else begin
                  record_counter_next = record_counter_next + 16'd1;
                  phase_next          = PH_RLEN;
                  varint_acc_next     = '0;
                  varint_count_next   = '0;
                end
              end
            end
          end
        end
      endcase
      if (result.status == ST_BUSY && bytes_remaining_next == '0) begin
        result.status = (phase_next == PH_RLEN && varint_count_next == '0) ?
                        ST_DONE_OK : ST_VARINT;
      end
      if (result.status != ST_BUSY) begin
        result.last = 1'b1;
        phase_next  = PH_IDLE;
      end
    end
    result.record_type = current_type_next;
  end

endmodule

// ===== sv/tvmp_out_reg.sv =====
`timescale 1ns / 1ps

module tvmp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  output logic                res_ready,
  input  tvmp_pkg::out_item_t res_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tvmp_pkg::out_item_t out_item
);
  import tvmp_pkg::*;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item <= res_item;
    end
  end

endmodule

// ===== sv/tlv_varint_message_parser.sv =====
`timescale 1ns / 1ps
// An accepted request is held in the input register, then the parse logic
// writes its result into the result register.
// Throughput: 1 byte per cycle unless out_ready stalls the result register.
// Reset: synchronous active-high rst clears both stages, parser state and
// max_version.

module tlv_varint_message_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tvmp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tvmp_pkg::out_item_t out_item,
  input  logic                max_version_we,
  input  logic [7:0]          max_version_wdata
);
  import tvmp_pkg::*;

  logic       max_version_valid_unused;
  logic [7:0] max_version;
  logic       held_valid;
  in_item_t   held_item;
  logic       res_ready;
  out_item_t  res_item;

  assign max_version_valid_unused = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_version <= '0;
    end else if (max_version_we) begin
      max_version <= max_version_wdata;
    end
  end

  tvmp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .held_take  (res_ready)
  );

  tvmp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (held_valid && res_ready && !max_version_valid_unused),
    .item        (held_item),
    .max_version (max_version),
    .result      (res_item)
  );

  tvmp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (held_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== sv/tvmp_checker.sv =====
`timescale 1ns / 1ps

module tvmp_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input tvmp_pkg::out_item_t out_item
);
  import tvmp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_last_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.last == (out_item.status != ST_BUSY)))
    else $error("last disagrees with status");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.varint_done |-> out_item.varint_value == 32'd0)
    else $error("varint value without completion");

  a_short_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_SHORT_BUF |-> out_item.role == ROLE_SIZE_WORD)
    else $error("short buffer on wrong role");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.role == ROLE_IGNORED |->
      out_item.status == ST_BUSY && !out_item.varint_done)
    else $error("ignored byte carries status");

endmodule

bind tlv_varint_message_parser tvmp_checker u_tvmp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ===== test/tlv_varint_message_parser_tb.sv =====
`timescale 1ns / 1ps

module tlv_varint_message_parser_tb;
  import tvmp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_BYTES    = 120;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        max_version_we;
  logic [7:0]  max_version_wdata;

  tlv_varint_message_parser u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_item           (in_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item          (out_item),
    .max_version_we    (max_version_we),
    .max_version_wdata (max_version_wdata)
  );

  always #1 clk = ~clk;

  // parser state mirror
  phase_t      parse_phase     = PH_IDLE;
  logic [15:0] buf_left        = '0;
  logic [31:0] shift_acc       = '0;
  logic [2:0]  cont_count      = '0;
  logic [31:0] rec_bytes_left  = '0;
  logic [31:0] name_bytes_left = '0;
  logic [3:0]  hdr_count       = '0;
  logic [31:0] cur_type        = '0;
  logic [15:0] rec_count       = '0;
  logic [31:0] size_acc        = '0;
  logic [7:0]  ver_limit       = '0;

  out_item_t due_tags[$];
  int        mismatches  = 0;
  int        msg_bytes   = 0;
  int        burst_left  = 0;
  int        stall_cycles = 0;
  bit        steady      = 1'b0;
  bit        hold_req    = 1'b0;

  function automatic void close_record();
    rec_count   = rec_count + 16'd1;
    parse_phase = PH_RLEN;
    shift_acc   = '0;
    cont_count  = '0;
  endfunction

  function automatic void finish_name();
    if (rec_bytes_left != 0) begin
      parse_phase = PH_VALUE;
    end else begin
      close_record();
    end
  endfunction

  function automatic out_item_t tag_byte(input in_item_t it);
    out_item_t   r;
    logic [31:0] v;
    r = '0;
    r.byte_out = it.data_byte;
    r.role     = ROLE_IGNORED;
    r.status   = ST_BUSY;
    if (it.start_req) begin
      buf_left        = it.buffer_size;
      shift_acc       = '0;
      cont_count      = '0;
      rec_bytes_left  = '0;
      name_bytes_left = '0;
      hdr_count       = '0;
      cur_type        = '0;
      rec_count       = '0;
      size_acc        = '0;
      parse_phase     = PH_SIZE;
      if (buf_left < 16'(SizeWordBytes)) begin
        r.role      = ROLE_SIZE_WORD;
        r.status    = ST_SHORT_BUF;
        r.last      = 1'b1;
        parse_phase = PH_IDLE;
      end
    end
    r.record_index = rec_count;
    if (parse_phase != PH_IDLE) begin
      r.role   = role_t'(3'(parse_phase - 3'd1));
      buf_left = buf_left - 16'd1;
      case (parse_phase)
        PH_SIZE: begin
          size_acc  = size_acc | ({24'd0, it.data_byte} << (8 * hdr_count[1:0]));
          hdr_count = hdr_count + 4'd1;
          if (hdr_count >= SizeWordBytes) begin
            if (size_acc > 32'(buf_left) + 32'(SizeWordBytes)) begin
              r.status = ST_SIZE_BIG;
            end else begin
              parse_phase = PH_VER;
              shift_acc   = '0;
              cont_count  = '0;
            end
          end
        end
        PH_NAME: begin
          name_bytes_left = name_bytes_left - 32'd1;
          if (name_bytes_left == 0) finish_name();
        end
        PH_VALUE: begin
          rec_bytes_left = rec_bytes_left - 32'd1;
          if (rec_bytes_left == 0) close_record();
        end
        default: begin
          if (parse_phase == PH_TYPE || parse_phase == PH_NLEN) begin
            hdr_count = hdr_count + 4'd1;
          end
          shift_acc = shift_acc | ({24'd0, it.data_byte & PayloadMask} << (7 * cont_count));
          if ((it.data_byte & ContBit) != 0) begin
            cont_count = cont_count + 3'd1;
            if (cont_count >= VarintMaxBytes) r.status = ST_VARINT;
          end else begin
            v              = shift_acc;
            r.varint_done  = 1'b1;
            r.varint_value = v;
            shift_acc      = '0;
            cont_count     = '0;
            case (parse_phase)
              PH_VER: begin
                if (v > 32'(ver_limit)) r.status = ST_BAD_VER;
                else parse_phase = PH_RLEN;
              end
              PH_RLEN: begin
                if (v > 32'(buf_left)) begin
                  r.status = ST_REC_OVR;
                end else begin
                  rec_bytes_left = v;
                  hdr_count      = '0;
                  parse_phase    = PH_TYPE;
                end
              end
              PH_TYPE: begin
                cur_type    = v;
                parse_phase = PH_NLEN;
              end
              default: begin
                if (v > 32'(buf_left) ||
                    {1'b0, v} + 33'(hdr_count) > {1'b0, rec_bytes_left}) begin
                  r.status = ST_NAME_OVR;
                end else begin
                  rec_bytes_left  = rec_bytes_left - 32'(hdr_count) - v;
                  name_bytes_left = v;
                  if (name_bytes_left != 0) parse_phase = PH_NAME;
                  else finish_name();
                end
              end
            endcase
          end
        end
      endcase
      if (r.status == ST_BUSY && buf_left == 16'd0) begin
        r.status = (parse_phase == PH_RLEN && cont_count == 0) ? ST_DONE_OK : ST_VARINT;
      end
      if (r.status != ST_BUSY) begin
        r.last      = 1'b1;
        parse_phase = PH_IDLE;
      end
    end
    r.record_type = cur_type;
    return r;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_tags.size() == 0) begin
        $error("result with no request pending: byte_out %0h", out_item.byte_out);
        mismatches++;
      end else begin
        want = due_tags.pop_front();
        compare_field("byte_out", want.byte_out, out_item.byte_out);
        compare_field("role", want.role, out_item.role);
        compare_field("record_index", want.record_index, out_item.record_index);
        compare_field("record_type", want.record_type, out_item.record_type);
        compare_field("varint_value", want.varint_value, out_item.varint_value);
        compare_field("varint_done", want.varint_done, out_item.varint_done);
        compare_field("status", want.status, out_item.status);
        compare_field("last", want.last, out_item.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int seg_left;
    int mode;
    int tick;
    seg_left  = 0;
    mode      = 0;
    tick      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 80);
        end
        seg_left--;
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (tick % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_byte(input in_item_t it);
    int gap;
    if (!steady && burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    due_tags.push_back(tag_byte(it));
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] q[$], input logic [15:0] bsz);
    in_item_t it;
    foreach (q[i]) begin
      it.data_byte   = q[i];
      it.start_req   = (i == 0);
      it.buffer_size = (i == 0) ? bsz : 16'($urandom);
      send_byte(it);
      msg_bytes++;
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (due_tags.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_version(input logic [7:0] v);
    max_version_we    <= 1'b1;
    max_version_wdata <= v;
    @(negedge clk);
    max_version_we    <= 1'b0;
    ver_limit = v;
  endtask

  function automatic int pad_count();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : 0;
  endfunction

  function automatic void put_varint(ref logic [7:0] q[$], input logic [31:0] v,
                                     input int pad);
    int         n;
    logic [7:0] b;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    n = (n + pad > 5) ? 5 : n + pad;
    for (int i = 0; i < n; i++) begin
      b = 8'(v >> (7 * i)) & PayloadMask;
      if (i == 4) b[6:4] = 3'($urandom);
      if (i < n - 1) b = b | ContBit;
      q.push_back(b);
    end
  endfunction

  function automatic void build_message(ref logic [7:0] q[$], input int n_rec,
                                        input bit bad_ver, input bit skew_len);
    logic [7:0]  body[$];
    logic [31:0] ver;
    logic [31:0] type_v;
    logic [31:0] rlen;
    logic [31:0] size_v;
    int          name_n;
    int          value_n;
    q.delete();
    repeat (4) q.push_back(8'h00);
    if (bad_ver && ver_limit != 8'hFF) ver = $urandom_range(ver_limit + 1, 255);
    else ver = $urandom_range(0, ver_limit);
    put_varint(q, ver, pad_count());
    for (int r = 0; r < n_rec; r++) begin
      body.delete();
      type_v  = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 300));
      name_n  = $urandom_range(0, 3);
      value_n = $urandom_range(0, 4);
      put_varint(body, type_v, pad_count());
      put_varint(body, 32'(name_n), pad_count());
      repeat (name_n + value_n) body.push_back(8'($urandom));
      rlen = 32'(body.size());
      if (skew_len && r == 0) begin
        case ($urandom_range(0, 2))
          0: rlen = rlen + 32'($urandom_range(1, 3));
          1: rlen = rlen - 32'd1;
          default: rlen = $urandom;
        endcase
      end
      put_varint(q, rlen, pad_count());
      foreach (body[i]) q.push_back(body[i]);
    end
    size_v = $urandom_range(0, q.size());
    for (int i = 0; i < 4; i++) q[i] = size_v[8 * i +: 8];
  endfunction

  task automatic run_message();
    logic [7:0]  q[$];
    logic [15:0] bsz;
    logic [31:0] big;
    in_item_t    it;
    int          kind;
    int          idx;
    kind = $urandom_range(0, 15);
    if (kind == 7) begin
      repeat ($urandom_range(3, 12)) begin
        it.data_byte   = 8'($urandom);
        it.start_req   = ($urandom_range(0, 5) == 0);
        it.buffer_size = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 12));
        send_byte(it);
      end
    end else begin
      build_message(q, $urandom_range(0, 4), kind == 5, kind == 6);
      bsz = 16'(q.size());
      case (kind)
        0: begin
          idx    = $urandom_range(0, q.size() - 1);
          q[idx] = 8'($urandom);
        end
        1: bsz = 16'($urandom_range(0, q.size() - 1));
        2: begin
          idx = $urandom_range(1, q.size());
          while (q.size() > idx) void'(q.pop_back());
        end
        3: bsz = bsz + 16'($urandom_range(1, 8));
        4: begin
          big = $urandom_range(0, 1) ? ($urandom | 32'h8000_0000)
                                     : 32'(q.size()) + 32'($urandom_range(1, 50));
          for (int i = 0; i < 4; i++) q[i] = big[8 * i +: 8];
        end
        default: ;
      endcase
      send_bytes(q, bsz);
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        it.data_byte   = 8'($urandom);
        it.start_req   = 1'b0;
        it.buffer_size = 16'($urandom);
        send_byte(it);
      end
    end
  endtask

  task automatic test_short_buffer();
    in_item_t it;
    it = '{data_byte: 8'hFF, start_req: 1'b0, buffer_size: 16'hFFFF};
    send_byte(it);
    it = '{data_byte: 8'h00, start_req: 1'b1, buffer_size: 16'h0000};
    send_byte(it);
  endtask

  task automatic test_size_word();
    logic [7:0] q[$];
    q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_bytes(q, 16'hFFFF);
    // drop this one by restarting mid-header
    q = '{8'h10, 8'h00};
    send_bytes(q, 16'd16);
  endtask

  task automatic test_varint_limits();
    logic [7:0] q[$];
    q = '{8'h09, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
    send_bytes(q, 16'd9);
    q = '{8'h05, 8'h00, 8'h00, 8'h00, 8'h81};
    send_bytes(q, 16'd5);
  endtask

  task automatic test_empty_record_list();
    logic [7:0] q[$];
    in_item_t   it;
    q = '{8'h05, 8'h00, 8'h00, 8'h00, 8'h00};
    send_bytes(q, 16'd5);
    it = '{data_byte: 8'h80, start_req: 1'b0, buffer_size: 16'h0000};
    send_byte(it);
  endtask

  task automatic test_backpressure();
    logic [7:0] q[$];
    wait_drain();
    steady   = 1'b1;
    hold_req = 1'b1;
    build_message(q, 6, 1'b0, 1'b0);
    send_bytes(q, 16'(q.size()));
    wait_drain();
    steady = 1'b0;
  endtask

  task automatic test_random_messages();
    logic [7:0] limits[4];
    int         target;
    limits = '{8'hFF, 8'($urandom_range(1, 254)), 8'h00, 8'h03};
    for (int p = 0; p < 4; p++) begin
      wait_drain();
      write_max_version(limits[p]);
      steady = (p == 2);
      target = msg_bytes + PHASE_BYTES;
      while (msg_bytes < target) begin
        run_message();
        if ($urandom_range(0, 9) == 0) wait_drain();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst               = 1'b1;
    in_valid          = 1'b0;
    in_item           = '0;
    max_version_we    = 1'b0;
    max_version_wdata = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_short_buffer();
    test_size_word();
    test_varint_limits();
    test_empty_record_list();
    test_backpressure();
    test_random_messages();
    wait_drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
